### design/stl_pkg.sv
`timescale 1ns / 1ps

package stl_pkg;

  typedef logic [11:0] width_t;
  typedef logic [7:0]  cmd_t;
  typedef logic [1:0]  reg_idx_t;

  typedef struct packed {
    logic [7:0] slew_step;
    width_t     upper_limit;
    width_t     lower_limit;
  } cfg_t;

  localparam int     CFG_DATA_W = 12;

  localparam reg_idx_t REG_SLEW_STEP   = 2'd0;
  localparam reg_idx_t REG_UPPER_LIMIT = 2'd1;
  localparam reg_idx_t REG_LOWER_LIMIT = 2'd2;

  localparam width_t RESET_WIDTH      = 12'd1500;
  localparam logic [7:0] RESET_SLEW   = 8'd30;
  localparam width_t RESET_UPPER      = 12'd2500;
  localparam width_t RESET_LOWER      = 12'd1500;

  localparam cmd_t   ANGLE_MIN  = 8'd90;
  localparam cmd_t   ANGLE_MAX  = 8'd180;
  localparam width_t ANGLE_BASE = 12'd500;

  // ceil(2^22 / 100); exact floor division by 100 for inputs below 43690.
  localparam logic [15:0] RECIP_100   = 16'd41944;
  localparam int          RECIP_SHIFT = 22;

  localparam cmd_t DOWN_FIRST = 8'd230;
  localparam cmd_t DOWN_LAST  = 8'd239;
  localparam cmd_t UP_FIRST   = 8'd240;
  localparam cmd_t UP_LAST    = 8'd249;

endpackage

### design/stl_next.sv
`timescale 1ns / 1ps

module stl_next (
  input  logic            action,
  input  stl_pkg::cmd_t   command,
  input  stl_pkg::width_t goal,
  input  stl_pkg::width_t cur,
  input  stl_pkg::cfg_t   cfg,
  output stl_pkg::width_t goal_nxt,
  output stl_pkg::width_t cur_nxt
);
  import stl_pkg::*;

  cmd_t        angle;
  logic [10:0] angle_x11;
  logic [26:0] quot_prod;
  logic [4:0]  quot;
  width_t      angle_goal;

  cmd_t        step_off;
  logic [3:0]  step_cnt;
  logic [6:0]  interval;
  logic [12:0] up_sum;
  logic [12:0] down_sum;
  width_t      up_goal;
  width_t      down_goal;

  width_t      diff;
  width_t      slew_ext;
  width_t      move;

  // Angle path: 500 + floor(1111*a/100) = 500 + 11*a + floor(11*a/100).
  always_comb begin
    if (command < ANGLE_MIN) begin
      angle = ANGLE_MIN;
    end else if (command > ANGLE_MAX) begin
      angle = ANGLE_MAX;
    end else begin
      angle = command;
    end
    angle_x11  = {angle, 3'b000} + {2'b00, angle, 1'b0} + {3'b000, angle};
    quot_prod  = 27'(angle_x11) * 27'(RECIP_100);
    quot       = quot_prod[RECIP_SHIFT +: 5];
    angle_goal = ANGLE_BASE + {1'b0, angle_x11} + {7'b0, quot};
  end

  // Step paths: interval = (n+1)*10, n taken from the low end of each range.
  always_comb begin
    step_off  = (command >= UP_FIRST) ? (command - UP_FIRST) : (command - DOWN_FIRST);
    step_cnt  = step_off[3:0] + 4'd1;
    interval  = {step_cnt, 3'b000} + {2'b00, step_cnt, 1'b0};
    up_sum    = {1'b0, goal} + {6'b0, interval};
    down_sum  = {1'b0, cfg.lower_limit} + {6'b0, interval};
    up_goal   = (up_sum >= {1'b0, cfg.upper_limit}) ? cfg.upper_limit : up_sum[11:0];
    down_goal = ({1'b0, goal} <= down_sum) ? cfg.lower_limit : (goal - width_t'(interval));
  end

  always_comb begin
    if (action) begin
      goal_nxt = goal;
    end else if (command inside {[DOWN_FIRST:DOWN_LAST]}) begin
      goal_nxt = down_goal;
    end else if (command inside {[UP_FIRST:UP_LAST]}) begin
      goal_nxt = up_goal;
    end else begin
      goal_nxt = angle_goal;
    end
  end

  // Tick: move the current width toward the goal by at most the slew step.
  always_comb begin
    slew_ext = {4'b0, cfg.slew_step};
    diff     = (cur > goal) ? (cur - goal) : (goal - cur);
    move     = (diff > slew_ext) ? slew_ext : diff;
    if (!action) begin
      cur_nxt = cur;
    end else if (cur > goal) begin
      cur_nxt = cur - move;
    end else begin
      cur_nxt = cur + move;
    end
  end

endmodule

### design/servo_target_slew_limiter.sv
`timescale 1ns / 1ps

// Servo target slew limiter.
// The input channel carries one beat per event: in_action low delivers a
// command byte in in_command (step down, step up or angle), in_action high is
// a servo period tick that slews the current width toward the target.
// Every input beat yields exactly one output beat with the current pulse
// width and the target width as they stand after that beat.
// Each accepted input beat waits in the input register while the update
// logic works on it, and the state registers, which also hold the result,
// load it when the update stage advances; out_valid rises as they load.
// One beat per cycle is sustained; the rate is set by the single update
// stage, which advances whenever the result register is empty or being
// drained.
// When out_ready is low the result holds, the update stage stalls, and the
// input register still takes one more beat, if it is empty, before in_ready
// drops.
// Configuration writes through cfg_we/cfg_index/cfg_wdata take effect at the
// next edge; index 3 is ignored. Reset sets both widths to 1500, slew step 30,
// upper limit 2500 and lower limit 1500, and empties the pipeline.

module servo_target_slew_limiter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  stl_pkg::cmd_t         in_command,
  output logic                  out_valid,
  input  logic                  out_ready,
  output stl_pkg::width_t       out_pulse_width,
  output stl_pkg::width_t       out_target_width,
  input  logic                  cfg_we,
  input  stl_pkg::reg_idx_t     cfg_index,
  input  logic [stl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import stl_pkg::*;

  logic   in_valid_r;
  logic   action_r;
  cmd_t   command_r;
  logic   out_valid_r;
  width_t goal_r;
  width_t cur_r;
  cfg_t   cfg_r;
  width_t goal_nxt;
  width_t cur_nxt;
  logic   advance;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;

  stl_next u_next (
    .action   (action_r),
    .command  (command_r),
    .goal     (goal_r),
    .cur      (cur_r),
    .cfg      (cfg_r),
    .goal_nxt (goal_nxt),
    .cur_nxt  (cur_nxt)
  );

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      action_r  <= in_action;
      command_r <= in_command;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      goal_r            <= RESET_WIDTH;
      cur_r             <= RESET_WIDTH;
      cfg_r.slew_step   <= RESET_SLEW;
      cfg_r.upper_limit <= RESET_UPPER;
      cfg_r.lower_limit <= RESET_LOWER;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SLEW_STEP:   cfg_r.slew_step   <= cfg_wdata[7:0];
          REG_UPPER_LIMIT: cfg_r.upper_limit <= cfg_wdata;
          REG_LOWER_LIMIT: cfg_r.lower_limit <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          goal_r <= goal_nxt;
          cur_r  <= cur_nxt;
        end
      end
    end
  end

  // The state registers only change when the result register is free, so
  // they double as the result payload.
  assign out_valid        = out_valid_r;
  assign out_pulse_width  = cur_r;
  assign out_target_width = goal_r;

endmodule

### design/stl_checker.sv
`timescale 1ns / 1ps

module stl_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input stl_pkg::width_t       out_pulse_width,
  input stl_pkg::width_t       out_target_width
);
  import stl_pkg::*;

  width_t last_pulse_r;
  logic   seen_r;
  width_t pulse_delta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      last_pulse_r <= out_pulse_width;
    end
  end

  assign pulse_delta = (out_pulse_width > last_pulse_r) ? (out_pulse_width - last_pulse_r)
                                                        : (last_pulse_r - out_pulse_width);

  // A reset always empties the result side.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pulse_width)
                                && $stable(out_target_width))
    else $error("stalled result beat changed");

  // Input back-pressure only appears while a result is held up downstream.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without a stalled result");

  // Successive results never move the pulse width by more than the largest slew step, 255.
  a_slew_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_r |-> pulse_delta <= 12'd255)
    else $error("pulse width moved more than the largest slew step");

  // A reset leaves the input register empty, so the block is ready at once.
  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("in_ready low right after reset");

endmodule

bind servo_target_slew_limiter stl_checker u_stl_checker (.*);
